@@ rtl/core/tbrrl_pkg.sv @@
`default_nettype none
package tbrrl_pkg;

    localparam int ROUTE_SLOTS  = 64;
    localparam int BUCKET_SLOTS = 64;
    localparam int IDX_W        = 6;
    localparam int TIME_W       = 48;
    localparam int PERIOD_W     = 32;
    localparam int COUNT_W      = 16;
    localparam int DUR_W        = 36;

    localparam logic [DUR_W-1:0]    MAX_RESET_MS      = 36'd31536000000;
    localparam logic [COUNT_W-1:0]  CAPACITY_DEFAULT  = 16'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT    = 32'd20;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_CHECK   = 2'd1;
    localparam logic [1:0] OP_UPDATE  = 2'd2;
    localparam logic [1:0] OP_GLOBAL  = 2'd3;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_PERIOD   = 2'd1;

    typedef struct packed {
        logic [1:0]               operation;
        logic [TIME_W-1:0]        now_ms;
        logic [IDX_W-1:0]         route_index;
        logic [IDX_W-1:0]         bucket_index;
        logic [COUNT_W-1:0]       remaining_count;
        logic signed [DUR_W-1:0]  duration_ms;
    } tbrrl_req_t;

    typedef struct packed {
        logic                 allowed;
        logic [TIME_W-1:0]    wait_ms;
        logic                 global_limited;
        logic [COUNT_W-1:0]   tokens_left;
    } tbrrl_rsp_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     route;
        logic [IDX_W-1:0]     bucket;
        logic [COUNT_W-1:0]   remaining;
        logic [TIME_W-1:0]    deadline;
    } tbrrl_wr_t;

    typedef struct packed {
        logic                 route_hit;
        logic [IDX_W-1:0]     route_bucket;
        logic                 bucket_hit;
        logic [COUNT_W-1:0]   remaining;
        logic [TIME_W-1:0]    deadline;
    } tbrrl_rd_t;

endpackage
`default_nettype wire

@@ rtl/core/tbrrl_div.sv @@
`default_nettype none
module tbrrl_div
    import tbrrl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [TIME_W-1:0]   dividend,
    input  wire logic [PERIOD_W-1:0] divisor,
    output logic                     done,
    output logic [TIME_W-1:0]        quotient,
    output logic [PERIOD_W-1:0]      remainder
);

    logic                  run_reg;
    logic                  done_reg;
    logic [5:0]            cnt_reg;
    logic [TIME_W-1:0]     quo_reg;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [PERIOD_W-1:0]   div_reg;
    logic [PERIOD_W:0]     trial;
    logic                  fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'(TIME_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[TIME_W-2:0], fits};
            rem_reg <= fits ? PERIOD_W'(trial - {1'b0, div_reg}) : trial[PERIOD_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ rtl/core/tbrrl_mem.sv @@
`default_nettype none
module tbrrl_mem
    import tbrrl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             route_rd,
    input  wire logic [IDX_W-1:0] route_addr,
    input  wire logic             bucket_rd,
    input  wire logic [IDX_W-1:0] bucket_addr,
    input  wire tbrrl_wr_t        wr,
    output tbrrl_rd_t             rd
);

    logic [IDX_W-1:0]   route_mem [0:ROUTE_SLOTS-1];
    logic [COUNT_W-1:0] rem_mem   [0:BUCKET_SLOTS-1];
    logic [TIME_W-1:0]  dl_mem    [0:BUCKET_SLOTS-1];
    logic [ROUTE_SLOTS-1:0]  route_valid_reg;
    logic [BUCKET_SLOTS-1:0] bucket_valid_reg;

    logic               route_hit_reg;
    logic [IDX_W-1:0]   route_data_reg;
    logic               bucket_hit_reg;
    logic [COUNT_W-1:0] rem_data_reg;
    logic [TIME_W-1:0]  dl_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_valid_reg  <= '0;
            bucket_valid_reg <= '0;
            route_hit_reg    <= 1'b0;
            bucket_hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                route_valid_reg[wr.route]   <= 1'b1;
                bucket_valid_reg[wr.bucket] <= 1'b1;
            end
            if (route_rd)
                route_hit_reg <= (7'(route_addr) < 7'(ROUTE_SLOTS))
                                 && route_valid_reg[route_addr];
            if (bucket_rd)
                bucket_hit_reg <= (7'(bucket_addr) < 7'(BUCKET_SLOTS))
                                  && bucket_valid_reg[bucket_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            route_mem[wr.route] <= wr.bucket;
            rem_mem[wr.bucket]  <= wr.remaining;
            dl_mem[wr.bucket]   <= wr.deadline;
        end
        if (route_rd)
            route_data_reg <= route_mem[route_addr];
        if (bucket_rd)
        begin
            rem_data_reg <= rem_mem[bucket_addr];
            dl_data_reg  <= dl_mem[bucket_addr];
        end
    end

    assign rd.route_hit    = route_hit_reg;
    assign rd.route_bucket = route_data_reg;
    assign rd.bucket_hit   = bucket_hit_reg;
    assign rd.remaining    = rem_data_reg;
    assign rd.deadline     = dl_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/token_bucket_route_rate_limiter_unit.sv @@
`default_nettype none
// check goes through states CK1 and CK2, update and set-global through UPD and GLB;
// acquire goes through DIV, REF and TAKE (bit-serial 48-bit refill divider) when time
// has moved past the last refill, else only TAKE; one request in flight at a time
// reset (async, active low) restores registers and clears all route and bucket valid bits
// in one step; there is no clearing pass, requests are taken right after reset
module token_bucket_route_rate_limiter_unit
    import tbrrl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire tbrrl_req_t        req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output tbrrl_rsp_t             rsp_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CK1  = 3'd1;
    localparam logic [2:0] ST_CK2  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_GLB  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_REF  = 3'd6;
    localparam logic [2:0] ST_TAKE = 3'd7;

    logic [2:0]          state_reg, state_next;
    tbrrl_req_t          cur_reg;
    logic [COUNT_W-1:0]  cap_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [COUNT_W-1:0]  token_reg;
    logic [TIME_W-1:0]   last_reg;
    logic [TIME_W-1:0]   gdl_reg;
    logic                rsp_valid_reg;
    tbrrl_rsp_t          rsp_data_reg;

    logic                accept;
    logic                out_free;
    logic                finish;
    tbrrl_rsp_t          result;
    logic [PERIOD_W-1:0] period_eff;
    logic [TIME_W-1:0]   dur_nn;
    logic                div_start;
    logic                div_done;
    logic [TIME_W-1:0]   div_quo;
    logic [PERIOD_W-1:0] div_rem;
    tbrrl_wr_t           wr;
    tbrrl_rd_t           rd;

    logic [TIME_W:0]     tok_sum;
    logic [COUNT_W-1:0]  tok_refill;
    logic [TIME_W:0]     next_refill;
    logic [TIME_W:0]     acq_wait;
    logic [TIME_W:0]     upd_dl;
    logic [TIME_W:0]     glb_dl;
    logic [DUR_W-1:0]    upd_dur;
    logic [TIME_W-1:0]   gdl_after;

    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign accept     = req_valid && !req_stall;
    assign req_stall  = state_reg != ST_IDLE;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready  = 1'b1;
    assign dur_nn     = cur_reg.duration_ms[DUR_W-1] ? '0
                        : TIME_W'(unsigned'(cur_reg.duration_ms));
    assign div_start  = accept && req_data.operation == OP_ACQUIRE
                        && req_data.now_ms > last_reg;

    tbrrl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req_data.now_ms - last_reg),
        .divisor   (period_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // update writes once, in the cycle its result leaves
    assign upd_dur = (unsigned'(cur_reg.duration_ms) > MAX_RESET_MS || cur_reg.duration_ms[DUR_W-1])
                     ? (cur_reg.duration_ms[DUR_W-1] ? '0 : MAX_RESET_MS)
                     : unsigned'(cur_reg.duration_ms);
    assign upd_dl  = {1'b0, cur_reg.now_ms} + (TIME_W+1)'(upd_dur);
    assign wr.en   = state_reg == ST_UPD && out_free
                     && 7'(cur_reg.route_index) < 7'(ROUTE_SLOTS)
                     && 7'(cur_reg.bucket_index) < 7'(BUCKET_SLOTS);
    assign wr.route     = cur_reg.route_index;
    assign wr.bucket    = cur_reg.bucket_index;
    assign wr.remaining = cur_reg.remaining_count;
    assign wr.deadline  = upd_dl[TIME_W] ? '1 : upd_dl[TIME_W-1:0];

    tbrrl_mem u_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .route_rd    (accept),
        .route_addr  (req_data.route_index),
        .bucket_rd   (state_reg == ST_CK1),
        .bucket_addr (rd.route_bucket),
        .wr          (wr),
        .rd          (rd)
    );

    // refill by whole periods, clamped to capacity
    assign tok_sum    = (TIME_W+1)'(token_reg) + {1'b0, div_quo};
    assign tok_refill = (tok_sum < (TIME_W+1)'(cap_reg)) ? tok_sum[COUNT_W-1:0] : cap_reg;

    assign next_refill = {1'b0, last_reg} + (TIME_W+1)'(period_eff);
    assign acq_wait    = (next_refill > {1'b0, cur_reg.now_ms})
                         ? next_refill - {1'b0, cur_reg.now_ms} : '0;

    assign glb_dl    = {1'b0, cur_reg.now_ms} + {1'b0, dur_nn};
    assign gdl_after = (state_reg == ST_GLB) ? (glb_dl[TIME_W] ? '1 : glb_dl[TIME_W-1:0])
                       : gdl_reg;

    always_comb
    begin
        result.allowed        = 1'b1;
        result.wait_ms        = '0;
        result.global_limited = gdl_after > cur_reg.now_ms;
        result.tokens_left    = token_reg;
        case (state_reg)
            ST_CK2:
            begin
                if (gdl_reg > cur_reg.now_ms)
                begin
                    result.allowed = 1'b0;
                    result.wait_ms = gdl_reg - cur_reg.now_ms;
                end
                else if (rd.route_hit && rd.bucket_hit && rd.remaining == '0
                         && rd.deadline > cur_reg.now_ms)
                begin
                    result.allowed = 1'b0;
                    result.wait_ms = rd.deadline - cur_reg.now_ms;
                end
            end
            ST_TAKE:
            begin
                if (token_reg != '0)
                    result.tokens_left = token_reg - COUNT_W'(1);
                else
                begin
                    result.allowed = 1'b0;
                    if (acq_wait[TIME_W])
                        result.wait_ms = '1;
                    else if (acq_wait[TIME_W-1:0] == '0)
                        result.wait_ms = TIME_W'(1);
                    else
                        result.wait_ms = acq_wait[TIME_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_data.operation)
                        OP_ACQUIRE: state_next = div_start ? ST_DIV : ST_TAKE;
                        OP_CHECK:   state_next = ST_CK1;
                        OP_UPDATE:  state_next = ST_UPD;
                        default:    state_next = ST_GLB;
                    endcase
                end
            end
            ST_CK1:  state_next = ST_CK2;
            ST_DIV:  state_next = div_done ? ST_REF : ST_DIV;
            ST_REF:  state_next = ST_TAKE;
            ST_CK2, ST_UPD, ST_GLB, ST_TAKE:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAPACITY_DEFAULT;
            period_reg    <= PERIOD_DEFAULT;
            token_reg     <= CAPACITY_DEFAULT;
            last_reg      <= '0;
            gdl_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CAPACITY)
                    cap_reg <= cfg_data[COUNT_W-1:0];
                else if (cfg_index == CFG_PERIOD)
                    period_reg <= cfg_data;
            end
            if (state_reg == ST_REF && div_quo != '0)
            begin
                token_reg <= tok_refill;
                last_reg  <= cur_reg.now_ms - TIME_W'(div_rem);
            end
            if (finish)
            begin
                token_reg <= result.tokens_left;
                gdl_reg   <= gdl_after;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cur_reg <= req_data;
        if (finish)
            rsp_data_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_check_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_data.operation == OP_CHECK) |=> state_reg == ST_CK1)
        else $error("check request did not start its route read");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_take_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAKE) |=> (state_reg == ST_TAKE || state_reg == ST_IDLE))
        else $error("acquire left its final state wrongly");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> state_reg == ST_IDLE)
        else $error("update wrote the tables without finishing");

endmodule
`default_nettype wire
